// File: rtl/cdq_pkg.sv
// Shared constants, opcodes and interface types of the circular deque.
package cdq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 3;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_STATUS     = 3'd4;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         addr;
    logic signed [WORD_W-1:0] data;
  } cdq_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] front;
    logic [IDX_W-1:0] rear;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cap;
    logic             full;
    logic             empty;
    logic             ok;
  } cdq_stat_t;

endpackage

// File: rtl/circular_deque_core.sv
// Top level of the circular deque: sequencer, slot store and result register.
// A double-ended ring queue of signed 32-bit words, up to 64 slots. Each input beat is
// one operation (push front, push rear, pop front, pop rear, status) and gives one
// result beat with the accept bit, the front and rear words (-1 when empty), the empty
// and full flags and the occupancy after the operation. The indices update and the store
// is written in the accept cycle, both ends are read from the slot store in ST_READ, and
// the read data lands in the result register in ST_LOAD, which holds while the result
// side has not taken the last result; no new beat is taken before the result is loaded.
// The slot store read starts only once the indices have settled. Writing the capacity
// (0 taken as 1, above 64 taken as 64) empties the queue; it is taken only while no
// operation is in flight.
module circular_deque_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cdq_pkg::CNT_W-1:0]         capacity_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cdq_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [cdq_pkg::WORD_W-1:0] data_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              accepted_o,
  output logic signed [cdq_pkg::WORD_W-1:0] front_word_o,
  output logic signed [cdq_pkg::WORD_W-1:0] rear_word_o,
  output logic                              empty_flag_o,
  output logic                              full_flag_o,
  output logic [cdq_pkg::CNT_W-1:0]         occupancy_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_beat, cfg_beat, load_en;

  cdq_pkg::cdq_wr_t   wr;
  cdq_pkg::cdq_stat_t stat;

  logic [cdq_pkg::WORD_W-1:0] rdata_front, rdata_rear;

  logic                              accepted_q;
  logic signed [cdq_pkg::WORD_W-1:0] front_word_q, rear_word_q;
  logic                              empty_q, full_q;
  logic [cdq_pkg::CNT_W-1:0]         occupancy_q;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_beat    = cfg_valid_i && cfg_ready_o;
  assign in_beat     = in_valid_i && in_ready_o;
  assign load_en     = (state_q == ST_LOAD) && (!out_valid_q || out_ready_i);

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_beat),
    .capacity_i  (capacity_i),
    .op_we_i     (in_beat),
    .opcode_i    (opcode_i),
    .data_value_i(data_value_i),
    .wr_o        (wr),
    .stat_o      (stat)
  );

  cdq_ram #(
    .Depth(cdq_pkg::DEPTH),
    .Width(cdq_pkg::WORD_W)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (wr.en),
    .waddr_i  (wr.addr),
    .wdata_i  (wr.data),
    .re_i     (state_q == ST_READ),
    .raddr_a_i(stat.front),
    .raddr_b_i(stat.rear),
    .rdata_a_o(rdata_front),
    .rdata_b_o(rdata_rear)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (load_en) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      accepted_q   <= stat.ok;
      front_word_q <= stat.empty ? cdq_pkg::EMPTY_WORD : $signed(rdata_front);
      rear_word_q  <= stat.empty ? cdq_pkg::EMPTY_WORD : $signed(rdata_rear);
      empty_q      <= stat.empty;
      full_q       <= stat.full;
      occupancy_q  <= stat.count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = accepted_q;
  assign front_word_o = front_word_q;
  assign rear_word_o  = rear_word_q;
  assign empty_flag_o = empty_q;
  assign full_flag_o  = full_q;
  assign occupancy_o  = occupancy_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= stat.cap)
    else $error("occupancy above capacity");

  a_beat_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_READ))
    else $error("accepted beat did not start a store read");

  a_load_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en |=> (out_valid_o && (state_q == ST_IDLE)))
    else $error("result not presented after load");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |=> (stat.count == $past(stat.count) + 7'd1))
    else $error("store write without count increment");

endmodule

// File: rtl/cdq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module cdq_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// File: rtl/cdq_ctrl.sv
// Index, count and capacity registers of the deque, with the store write request.
module cdq_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cdq_pkg::CNT_W-1:0]        capacity_i,
  input  logic                             op_we_i,
  input  logic [cdq_pkg::OP_W-1:0]         opcode_i,
  input  logic signed [cdq_pkg::WORD_W-1:0] data_value_i,
  output cdq_pkg::cdq_wr_t                 wr_o,
  output cdq_pkg::cdq_stat_t               stat_o
);

  logic [cdq_pkg::IDX_W-1:0] front_q, front_d;
  logic [cdq_pkg::IDX_W-1:0] rear_q, rear_d;
  logic [cdq_pkg::CNT_W-1:0] count_q, count_d;
  logic [cdq_pkg::CNT_W-1:0] cap_q, cap_d;
  logic                      ok_q, ok_d;

  logic [cdq_pkg::IDX_W-1:0] cap_m1;
  logic [cdq_pkg::IDX_W-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic [cdq_pkg::CNT_W-1:0] cap_new;
  logic                      full, empty;

  assign full   = (count_q == cap_q);
  assign empty  = (count_q == '0);
  assign cap_m1 = cdq_pkg::IDX_W'(cap_q - cdq_pkg::CNT_W'(1));

  assign front_inc = ((cdq_pkg::CNT_W'(front_q) + cdq_pkg::CNT_W'(1)) < cap_q) ?
                     front_q + cdq_pkg::IDX_W'(1) : '0;
  assign rear_inc  = ((cdq_pkg::CNT_W'(rear_q) + cdq_pkg::CNT_W'(1)) < cap_q) ?
                     rear_q + cdq_pkg::IDX_W'(1) : '0;
  assign front_dec = (front_q != '0) ? front_q - cdq_pkg::IDX_W'(1) : cap_m1;
  assign rear_dec  = (rear_q != '0) ? rear_q - cdq_pkg::IDX_W'(1) : cap_m1;

  always_comb begin
    if (capacity_i == '0) begin
      cap_new = cdq_pkg::CNT_W'(1);
    end else if (capacity_i > cdq_pkg::CNT_W'(cdq_pkg::DEPTH)) begin
      cap_new = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
    end else begin
      cap_new = capacity_i;
    end
  end

  always_comb begin
    front_d      = front_q;
    rear_d       = rear_q;
    count_d      = count_q;
    cap_d        = cap_q;
    ok_d         = ok_q;
    wr_o.en      = 1'b0;
    wr_o.addr    = front_inc;
    wr_o.data    = data_value_i;
    if (cfg_we_i) begin
      cap_d   = cap_new;
      front_d = cdq_pkg::IDX_W'(cap_new - cdq_pkg::CNT_W'(1));
      rear_d  = '0;
      count_d = '0;
    end else if (op_we_i) begin
      ok_d = 1'b0;
      unique case (opcode_i)
        cdq_pkg::OP_PUSH_FRONT: begin
          if (!full) begin
            front_d   = front_inc;
            wr_o.en   = 1'b1;
            wr_o.addr = front_inc;
            count_d   = count_q + cdq_pkg::CNT_W'(1);
            ok_d      = 1'b1;
          end
        end
        cdq_pkg::OP_PUSH_REAR: begin
          if (!full) begin
            rear_d    = rear_dec;
            wr_o.en   = 1'b1;
            wr_o.addr = rear_dec;
            count_d   = count_q + cdq_pkg::CNT_W'(1);
            ok_d      = 1'b1;
          end
        end
        cdq_pkg::OP_POP_FRONT: begin
          if (!empty) begin
            front_d = front_dec;
            count_d = count_q - cdq_pkg::CNT_W'(1);
            ok_d    = 1'b1;
          end
        end
        cdq_pkg::OP_POP_REAR: begin
          if (!empty) begin
            rear_d  = rear_inc;
            count_d = count_q - cdq_pkg::CNT_W'(1);
            ok_d    = 1'b1;
          end
        end
        cdq_pkg::OP_STATUS: begin
          ok_d = 1'b1;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
      rear_q  <= '0;
      count_q <= '0;
      cap_q   <= cdq_pkg::CNT_W'(cdq_pkg::DEPTH);
      ok_q    <= 1'b0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
      cap_q   <= cap_d;
      ok_q    <= ok_d;
    end
  end

  assign stat_o.front = front_q;
  assign stat_o.rear  = rear_q;
  assign stat_o.count = count_q;
  assign stat_o.cap   = cap_q;
  assign stat_o.full  = full;
  assign stat_o.empty = empty;
  assign stat_o.ok    = ok_q;

endmodule
